FILE: hw/rtl/brb_pkg.sv
package brb_pkg;

   // Request opcodes
   localparam logic [2:0] OP_PUSH       = 3'd0;
   localparam logic [2:0] OP_PUSH_POINT = 3'd1;
   localparam logic [2:0] OP_POP        = 3'd2;
   localparam logic [2:0] OP_DROP       = 3'd3;
   localparam logic [2:0] OP_CLEAR      = 3'd4;
   localparam logic [2:0] OP_PEEK_BW    = 3'd5;   // behind write pointer
   localparam logic [2:0] OP_PEEK_AR    = 3'd6;   // ahead of read pointer
   localparam logic [2:0] OP_PEEK_BR    = 3'd7;   // behind read pointer

   // Request payload
   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_in;
      logic [7:0] offset;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [7:0] data_out;
      logic [7:0] fill_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic exec;       // update pointers, write/read the store
      logic load_out;   // load the response register
   } cmd_type;

endpackage

FILE: hw/rtl/byte_ring_buffer_with_peek.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_payload (opcode, data_in, offset)
// rsp       out        rsp_valid / rsp_ready  rsp_payload (data_out, fill_count)
//
// Each request passes through three steps: capture, execute (store write, pointer
// update and registered store read), finish (response register load).
// The registered store read is why finish follows execute.
// A new request is taken while the previous response still waits.
// Reset is synchronous and clears the pointers and handshake state; the
// store is not cleared. A held response stalls the next request in finish.
module byte_ring_buffer_with_peek #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  brb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output brb_pkg::rsp_type rsp_payload
);
   import brb_pkg::*;

   cmd_type cmd;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   brb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .reset       (reset),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hw/rtl/brb_ctrl.sv
module brb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output brb_pkg::cmd_type cmd
);
   import brb_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Handshake and commands
   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      cmd.capture  = req_valid && (state_ff == S_IDLE);
      cmd.exec     = (state_ff == S_EXEC);
      cmd.load_out = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (cmd.load_out) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A captured request always executes next cycle
   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_EXEC))
      else $error("request not executed after capture");

   // Execution is followed by the finish state
   a_exec_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (state_ff == S_FIN))
      else $error("execute not followed by finish");

   // A loaded response is presented next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded response not presented");

   // Finish waits while the response register is held
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_FIN))
      else $error("finish left with response register busy");

endmodule

FILE: hw/rtl/brb_datapath.sv
module brb_datapath #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  brb_pkg::req_type req_payload,
   input  brb_pkg::cmd_type cmd,
   input  logic             reset,
   output brb_pkg::rsp_type rsp_payload
);
   import brb_pkg::*;

   localparam int          PW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW:0] DEPTH_W  = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

   // Offset reduced modulo depth, built at elaboration
   logic [PW-1:0] off_mod_tbl [256];
   for (genvar i = 0; i < 256; i++) begin : g_off_mod
      assign off_mod_tbl[i] = PW'(i % DEPTH);
   end

   logic [2:0]    op_ff;
   logic [7:0]    data_ff;
   logic [PW-1:0] off_ff;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   rsp_type       rsp_ff;

   logic [PW-1:0] base, rd_dist, rd_addr, wp_inc, rp_inc;
   logic [PW:0]   sum_add, sum_sub, addr_wide, diff_wide;
   logic [31:0]   fill_wide;
   logic          mem_we, is_read;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_payload.opcode;
         data_ff <= req_payload.data_in;
         off_ff  <= off_mod_tbl[req_payload.offset];
      end
   end

   // Read address: one modular add or subtract
   always_comb begin
      base    = (op_ff == OP_PEEK_BW) ? wp_ff : rp_ff;
      rd_dist = (op_ff == OP_POP) ? '0 : off_ff;
      sum_add = {1'b0, base} + {1'b0, rd_dist};
      sum_sub = {1'b0, base} + DEPTH_W - {1'b0, rd_dist};
      if (op_ff == OP_PEEK_AR) addr_wide = sum_add;
      else                     addr_wide = sum_sub;
      if (addr_wide >= DEPTH_W) addr_wide = addr_wide - DEPTH_W;
      rd_addr = addr_wide[PW-1:0];
   end

   // Pointer updates
   always_comb begin
      wp_inc = (wp_ff == LAST_P) ? '0 : wp_ff + PW'(1);
      rp_inc = (rp_ff == LAST_P) ? '0 : rp_ff + PW'(1);
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      mem_we = 1'b0;
      if (cmd.exec) begin
         unique case (op_ff)
            OP_PUSH: begin
               mem_we = 1'b1;
               wp_in  = wp_inc;
            end
            OP_PUSH_POINT: begin
               mem_we = 1'b1;
               rp_in  = wp_ff;
               wp_in  = wp_inc;
            end
            OP_POP: begin
               rp_in = rp_inc;
            end
            OP_DROP: begin
               rp_in = wp_ff;
            end
            OP_CLEAR: begin
               wp_in = '0;
               rp_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   // Byte store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[wp_ff] <= data_ff;
      if (cmd.exec) rd_data_ff <= mem[rd_addr];
   end

   // Fill count from updated pointers
   always_comb begin
      diff_wide = {1'b0, wp_ff} + DEPTH_W - {1'b0, rp_ff};
      if (diff_wide >= DEPTH_W) diff_wide = diff_wide - DEPTH_W;
      fill_wide = 32'(diff_wide);
      is_read   = (op_ff == OP_POP) || (op_ff == OP_PEEK_BW) ||
                  (op_ff == OP_PEEK_AR) || (op_ff == OP_PEEK_BR);
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.data_out   <= is_read ? rd_data_ff : 8'd0;
         rsp_ff.fill_count <= fill_wide[7:0];
      end
   end

   assign rsp_payload = rsp_ff;

   // Pointers and store address stay inside the store
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, wp_ff} < DEPTH_W) && ({1'b0, rp_ff} < DEPTH_W))
      else $error("pointer out of range");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> ({1'b0, rd_addr} < DEPTH_W))
      else $error("read address out of range");

endmodule
